@@ rtl/pkcs1_v15_block_unpadder_macros.svh @@
// Assertion macros for the PKCS#1 v1.5 block unpadder.
// Used by the RTL files that carry concurrent checks; they expect i_clk and i_rst_n in scope.
`ifndef PKCS1_V15_BLOCK_UNPADDER_MACROS_SVH
`define PKCS1_V15_BLOCK_UNPADDER_MACROS_SVH

// Same-cycle implication, off while reset is held
`define PK1U_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define PK1U_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pk1u_pkg.sv @@
// Shared types and constants of the PKCS#1 v1.5 block unpadder.
// No dependencies; used by the interfaces and every module.
`default_nettype none

package pk1u_pkg;

    // Block geometry
    localparam int unsigned MAX_BLOCK_BYTES = 512;
    localparam int unsigned POS_W           = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int unsigned CNT_W           = 10;
    localparam int unsigned CAP_W           = 10;

    // Fixed byte values and positions of the padding format
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] BYTE_TYPE1  = 8'h01;
    localparam logic [7:0] BYTE_TYPE2  = 8'h02;
    localparam logic [7:0] BYTE_FF     = 8'hFF;
    localparam int unsigned SEP_MIN_POS = 10;
    localparam int unsigned MIN_BLOCK   = 11;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP  = 1'b1;
    localparam logic [CAP_W-1:0]     CAP_RESET = 10'd512;

    // Status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_HDR   = 3'd2,
        ST_BAD_PAD   = 3'd3,
        ST_NO_SEP    = 3'd4,
        ST_MSG_LONG  = 3'd5,
        ST_BLK_LONG  = 3'd6
    } t_pk1u_status;

    // Scan phase
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_PAD    = 4'b0010,
        PH_MSG    = 4'b0100,
        PH_REJECT = 4'b1000
    } t_pk1u_phase;

    // Register values seen by the parser
    typedef struct packed {
        logic             mode;
        logic [CAP_W-1:0] cap;
    } t_pk1u_cfg;

    // One parser result
    typedef struct packed {
        logic       produce;
        logic [7:0] msg_byte;
        logic       msg_valid;
        logic       done_res;
        logic [2:0] status;
    } t_pk1u_res;

endpackage

`default_nettype wire

@@ rtl/pk1u_ifs.sv @@
// Channel interfaces of the PKCS#1 v1.5 block unpadder: input bytes, results, register writes.
// Depends on pk1u_pkg.
`default_nettype none

interface pk1u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface pk1u_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       msg_valid;
    logic       done_res;
    logic [2:0] status;

    modport source (output valid, output msg_byte, output msg_valid, output done_res,
                    output status, input ready);
    modport sink   (input valid, input msg_byte, input msg_valid, input done_res,
                    input status, output ready);
endinterface

interface pk1u_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pk1u_pkg::CFG_IDX_W-1:0]  index;
    logic [pk1u_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/pk1u_cfg.sv @@
// Configuration registers (mode, plaintext capacity) of the block unpadder.
// Depends on pk1u_pkg and pk1u_ifs.
`default_nettype none

module pk1u_cfg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    pk1u_cfg_if.sink             i_cfg,
    output pk1u_pkg::t_pk1u_cfg  o_cfg
);

    logic                        r_mode;
    logic [pk1u_pkg::CAP_W-1:0]  r_cap;

    // Always take writes
    assign i_cfg.ready = 1'b1;

    // Decode the register index and store the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_cap  <= pk1u_pkg::CAP_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pk1u_pkg::CFG_MODE: r_mode <= i_cfg.data[0];
                pk1u_pkg::CFG_CAP:  r_cap  <= i_cfg.data[pk1u_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.mode = r_mode;
    assign o_cfg.cap  = r_cap;

endmodule

`default_nettype wire

@@ rtl/pk1u_parser.sv @@
// Padding parser of the block unpadder: scan state and the one-step decision per byte.
// Depends on pk1u_pkg and the assertion macros header.
`default_nettype none
`include "pkcs1_v15_block_unpadder_macros.svh"

module pk1u_parser (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_fire,
    input  wire  [7:0]                i_byte,
    input  wire                       i_last,
    input  wire pk1u_pkg::t_pk1u_cfg  i_cfg,
    output pk1u_pkg::t_pk1u_res       o_res
);

    localparam logic [pk1u_pkg::POS_W-1:0] POS_MAX =
        pk1u_pkg::POS_W'(pk1u_pkg::MAX_BLOCK_BYTES);
    localparam logic [pk1u_pkg::POS_W-1:0] POS_SEP =
        pk1u_pkg::POS_W'(pk1u_pkg::SEP_MIN_POS);
    localparam logic [pk1u_pkg::POS_W-1:0] POS_MIN =
        pk1u_pkg::POS_W'(pk1u_pkg::MIN_BLOCK);

    logic [pk1u_pkg::POS_W-1:0]  r_pos,   n_pos;
    pk1u_pkg::t_pk1u_phase       r_phase, n_phase;
    pk1u_pkg::t_pk1u_status      r_err,   n_err;
    logic [pk1u_pkg::CNT_W-1:0]  r_cnt,   n_cnt;
    logic                        emit;
    logic [7:0]                  hdr_type;
    logic                        sep_hit;
    pk1u_pkg::t_pk1u_status      status;
    logic                        scan_clean;
    logic                        scan_idle;

    assign hdr_type = i_cfg.mode ? pk1u_pkg::BYTE_TYPE2 : pk1u_pkg::BYTE_TYPE1;
    assign sep_hit  = (i_byte == pk1u_pkg::BYTE_ZERO) && (r_pos >= POS_SEP);

    // Next scan state for the byte in the input register
    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_err   = r_err;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        if (r_pos >= POS_MAX) begin
            n_err = pk1u_pkg::ST_BLK_LONG;
        end else begin
            n_pos = r_pos + 1'b1;
            unique case (r_phase)
                pk1u_pkg::PH_HEADER: begin
                    if (r_pos == '0) begin
                        if (i_byte != pk1u_pkg::BYTE_ZERO && r_err == pk1u_pkg::ST_OK)
                            n_err = pk1u_pkg::ST_BAD_HDR;
                    end else begin
                        if (i_byte != hdr_type && r_err == pk1u_pkg::ST_OK)
                            n_err = pk1u_pkg::ST_BAD_HDR;
                        n_phase = pk1u_pkg::PH_PAD;
                    end
                end
                pk1u_pkg::PH_PAD: begin
                    if (!i_cfg.mode) begin
                        if (i_byte == pk1u_pkg::BYTE_FF) begin
                            n_phase = pk1u_pkg::PH_PAD;
                        end else if (sep_hit) begin
                            n_phase = pk1u_pkg::PH_MSG;
                        end else begin
                            if (r_err == pk1u_pkg::ST_OK)
                                n_err = pk1u_pkg::ST_BAD_PAD;
                            n_phase = pk1u_pkg::PH_REJECT;
                        end
                    end else if (sep_hit) begin
                        n_phase = pk1u_pkg::PH_MSG;
                    end
                end
                pk1u_pkg::PH_MSG: begin
                    if (r_err == pk1u_pkg::ST_OK) begin
                        if (i_cfg.mode && r_cnt >= i_cfg.cap) begin
                            n_err = pk1u_pkg::ST_MSG_LONG;
                        end else begin
                            emit = 1'b1;
                            if (r_cnt != '1)
                                n_cnt = r_cnt + 1'b1;
                        end
                    end
                end
                pk1u_pkg::PH_REJECT: ;
                default: ;
            endcase
        end
    end

    // Final status from the updated state
    always_comb begin
        if (!i_last)
            status = pk1u_pkg::ST_OK;
        else if (n_pos < POS_MIN)
            status = pk1u_pkg::ST_SHORT;
        else if (n_err != pk1u_pkg::ST_OK)
            status = n_err;
        else if (n_phase != pk1u_pkg::PH_MSG)
            status = pk1u_pkg::ST_NO_SEP;
        else
            status = pk1u_pkg::ST_OK;
    end

    assign o_res.produce   = emit || i_last;
    assign o_res.msg_byte  = emit ? i_byte : pk1u_pkg::BYTE_ZERO;
    assign o_res.msg_valid = emit;
    assign o_res.done_res  = i_last;
    assign o_res.status    = status;

    // Advance the scan state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= pk1u_pkg::PH_HEADER;
            r_err   <= pk1u_pkg::ST_OK;
            r_cnt   <= '0;
        end else if (i_fire) begin
            if (i_last) begin
                r_pos   <= '0;
                r_phase <= pk1u_pkg::PH_HEADER;
                r_err   <= pk1u_pkg::ST_OK;
                r_cnt   <= '0;
            end else begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_err   <= n_err;
                r_cnt   <= n_cnt;
            end
        end
    end

    // Scan conditions watched by the checks below
    assign scan_clean = (r_phase == pk1u_pkg::PH_MSG) && (r_err == pk1u_pkg::ST_OK);
    assign scan_idle  = (r_pos == '0) && (r_phase == pk1u_pkg::PH_HEADER) &&
                        (r_err == pk1u_pkg::ST_OK) && (r_cnt == '0);

    `PK1U_ASSERT_IMP(a_emit_clean, emit, scan_clean, "message byte outside a clean message phase")
    `PK1U_ASSERT_NXT(a_block_clear, i_fire && i_last, scan_idle, "scan state kept after last byte")
    `PK1U_ASSERT_IMP(a_pos_bound, 1'b1, r_pos <= POS_MAX, "byte position beyond block limit")
    `PK1U_ASSERT_IMP(a_status_done, !i_last, status == pk1u_pkg::ST_OK, "status on a non-final word")

endmodule

`default_nettype wire

@@ rtl/pkcs1_v15_block_unpadder.sv @@
// Each result word passes the input register and then the result register before it is on o_out.
// One byte per cycle while the result register can take a word; a single parser step lies between the two registers.
// Bytes that yield no result (header, padding, rejected) still wait for a free result register.
// Reset (i_rst_n low, synchronous): mode 0, capacity 512, scan state cleared, both stages empty.
// Depends on pk1u_pkg, pk1u_ifs, pk1u_cfg and pk1u_parser.
`default_nettype none

module pkcs1_v15_block_unpadder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pk1u_in_if.sink     i_in,
    pk1u_out_if.source  o_out,
    pk1u_cfg_if.sink    i_cfg
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic                 r_out_valid;
    pk1u_pkg::t_pk1u_res  r_out;
    pk1u_pkg::t_pk1u_res  res;
    pk1u_pkg::t_pk1u_cfg  cfg;
    logic                 out_free;
    logic                 fire;

    pk1u_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pk1u_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Process the held byte when the result register can take a word
    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last;
        end
    end

    // Result register: load on a produced word, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res.produce) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.produce) begin
            r_out <= res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.msg_byte  = r_out.msg_byte;
    assign o_out.msg_valid = r_out.msg_valid;
    assign o_out.done_res  = r_out.done_res;
    assign o_out.status    = r_out.status;

endmodule

`default_nettype wire
